@@ hw/rtl/drt_pkg.sv @@
`timescale 1ns / 1ps

package drt_pkg;

  // Default sizing
  localparam int FIELD_MAX_DEF = 64;
  localparam int LINE_MAX_DEF  = 65536;

  // Configuration port
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 32;

  localparam logic [CFG_INDEX_W-1:0] REG_DELIMITER       = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_EXPECTED_FIELDS = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_BAD_ROW_LIMIT   = 2'd2;

  localparam logic [7:0] DELIMITER_RESET = 8'd44;

  // Special bytes
  localparam logic [7:0] CHAR_NL  = 8'h0A;
  localparam logic [7:0] CHAR_NUL = 8'h00;

  // Line status codes
  localparam logic [2:0] ST_WITHIN    = 3'd0;
  localparam logic [2:0] ST_ACCEPTED  = 3'd1;
  localparam logic [2:0] ST_DROP_FEW  = 3'd2;
  localparam logic [2:0] ST_DROP_MANY = 3'd3;
  localparam logic [2:0] ST_ABORTED   = 3'd4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_input;
  } text_req_t;

  typedef struct packed {
    logic [5:0]  field_index;
    logic [15:0] field_start;
    logic [15:0] field_length;
    logic [31:0] line_number;
    logic        has_field;
    logic        end_of_line;
    logic [2:0]  line_status;
    logic        index_saturated;
  } record_req_t;

  // Record produced by the tokenizer core for the output stage
  typedef struct packed {
    logic        valid;
    record_req_t rec;
  } core_result_t;

endpackage

@@ hw/rtl/drt_if.sv @@
`timescale 1ns / 1ps

interface drt_text_if;
  import drt_pkg::*;
  logic      valid;
  logic      ready;
  text_req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface drt_record_if;
  import drt_pkg::*;
  logic        valid;
  logic        ready;
  record_req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

@@ hw/rtl/drt_core.sv @@
`timescale 1ns / 1ps

module drt_core import drt_pkg::*; #(
  parameter int FIELD_MAX = FIELD_MAX_DEF,
  parameter int LINE_MAX  = LINE_MAX_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   accept,
  input  text_req_t              req,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  output core_result_t           result
);

  localparam int FW = $clog2(FIELD_MAX + 1);
  localparam int LW = $clog2(LINE_MAX);
  localparam logic [LW-1:0] LINE_LAST = LW'(LINE_MAX - 1);

  // Configuration registers
  logic [7:0]  delimiter;
  logic [6:0]  expected_fields;
  logic [31:0] bad_row_limit;

  // Tokenizer state
  logic [31:0]   current_line, current_line_next;
  logic [FW-1:0] fields_seen, fields_seen_next;
  logic [LW-1:0] line_position, line_position_next;
  logic [LW-1:0] current_field_start, current_field_start_next;
  logic          skipping_bad_row, skipping_bad_row_next;
  logic [31:0]   bad_rows_counted, bad_rows_counted_next;
  logic          halted, halted_next;

  logic [7:0]    exp8, fs8;
  logic          strict;
  logic [LW-1:0] pos_adv;
  logic [31:0]   bad_inc;
  logic          abort;
  logic [5:0]    idx;
  logic          idx_sat;
  logic [LW-1:0] len;
  record_req_t   field_rec, status_rec;

  always_ff @(posedge clk) begin
    if (rst) begin
      delimiter       <= DELIMITER_RESET;
      expected_fields <= '0;
      bad_row_limit   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DELIMITER:       delimiter       <= cfg_wdata[7:0];
        REG_EXPECTED_FIELDS: expected_fields <= cfg_wdata[6:0];
        REG_BAD_ROW_LIMIT:   bad_row_limit   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    exp8    = (expected_fields > 7'(FIELD_MAX)) ? 8'(FIELD_MAX) : 8'(expected_fields);
    strict  = (exp8 != 8'd0);
    fs8     = 8'(fields_seen);
    pos_adv = (line_position < LINE_LAST) ? LW'(line_position + 1'b1) : line_position;
    bad_inc = (bad_rows_counted == 32'hFFFF_FFFF) ? bad_rows_counted
                                                 : bad_rows_counted + 32'd1;
    abort   = (bad_inc > bad_row_limit);
    idx     = (fs8 < 8'(FIELD_MAX - 1)) ? fs8[5:0] : 6'(FIELD_MAX - 1);
    idx_sat = (fs8 >= 8'(FIELD_MAX));
    len     = LW'(line_position - current_field_start);

    field_rec                 = '0;
    field_rec.field_index     = idx;
    field_rec.field_start     = 16'(current_field_start);
    field_rec.field_length    = 16'(len);
    field_rec.line_number     = current_line;
    field_rec.has_field       = 1'b1;
    field_rec.index_saturated = idx_sat;

    status_rec             = '0;
    status_rec.line_number = current_line;
    status_rec.end_of_line = 1'b1;
  end

  always_comb begin
    current_line_next        = current_line;
    fields_seen_next         = fields_seen;
    line_position_next       = line_position;
    current_field_start_next = current_field_start;
    skipping_bad_row_next    = skipping_bad_row;
    bad_rows_counted_next    = bad_rows_counted;
    halted_next              = halted;
    result                   = '0;

    if (accept && !halted) begin
      if (req.end_of_input) begin
        halted_next = 1'b1;
      end else if (req.data_byte == CHAR_NUL) begin
        // dropped
      end else if (req.data_byte == CHAR_NL) begin
        result.valid = 1'b1;
        if (skipping_bad_row) begin
          result.rec             = status_rec;
          result.rec.line_status = ST_DROP_MANY;
        end else if (strict && (fs8 >= exp8 || fs8 + 8'd1 < exp8)) begin
          bad_rows_counted_next = bad_inc;
          result.rec            = status_rec;
          if (abort) begin
            halted_next            = 1'b1;
            result.rec.line_status = ST_ABORTED;
          end else begin
            result.rec.line_status = (fs8 >= exp8) ? ST_DROP_MANY : ST_DROP_FEW;
          end
        end else begin
          result.rec             = field_rec;
          result.rec.end_of_line = 1'b1;
          result.rec.line_status = ST_ACCEPTED;
        end
        // start the next line unless aborted
        if (!halted_next) begin
          current_line_next        = current_line + 32'd1;
          fields_seen_next         = '0;
          line_position_next       = '0;
          current_field_start_next = '0;
          skipping_bad_row_next    = 1'b0;
        end
      end else if (req.data_byte == delimiter) begin
        line_position_next = pos_adv;
        if (skipping_bad_row) begin
          // rest of a surplus line is ignored
        end else if (strict && fs8 >= exp8) begin
          bad_rows_counted_next = bad_inc;
          if (abort) begin
            halted_next            = 1'b1;
            result.valid           = 1'b1;
            result.rec             = status_rec;
            result.rec.line_status = ST_ABORTED;
          end else begin
            skipping_bad_row_next = 1'b1;
          end
        end else begin
          result.valid = 1'b1;
          result.rec   = field_rec;
          if (fs8 < 8'(FIELD_MAX)) fields_seen_next = FW'(fields_seen + 1'b1);
          current_field_start_next = pos_adv;
        end
      end else begin
        line_position_next = pos_adv;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_line        <= '0;
      fields_seen         <= '0;
      line_position       <= '0;
      current_field_start <= '0;
      skipping_bad_row    <= 1'b0;
      bad_rows_counted    <= '0;
      halted              <= 1'b0;
    end else begin
      current_line        <= current_line_next;
      fields_seen         <= fields_seen_next;
      line_position       <= line_position_next;
      current_field_start <= current_field_start_next;
      skipping_bad_row    <= skipping_bad_row_next;
      bad_rows_counted    <= bad_rows_counted_next;
      halted              <= halted_next;
    end
  end

endmodule

@@ hw/rtl/drt_out_stage.sv @@
`timescale 1ns / 1ps

module drt_out_stage import drt_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  core_result_t result,
  output logic         ready_up,
  output logic         valid,
  input  logic         ready,
  output record_req_t  payload
);

  // Holds one record; refills in the cycle it drains
  assign ready_up = !valid || ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ready_up) begin
      valid <= result.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_up && result.valid) begin
      payload <= result.rec;
    end
  end

endmodule

@@ hw/rtl/delimited_record_tokenizer_unit.sv @@
`timescale 1ns / 1ps

// Delimited record tokenizer.
// text   : byte request channel (data_byte, end_of_input), valid/ready.
// record : one record per field end or per line status, valid/ready.
// cfg_*  : write-only register port; index 0 delimiter, 1 expected_fields,
//          2 bad_row_limit. Write only while the block is idle.
// Throughput: one byte per cycle unless the record side stalls. Each byte is
// classified and the line counters updated in the cycle it is accepted; the
// record it causes sits in the output register on the next cycle.
// Stall: text.ready = !record.valid || record.ready, so a byte is taken in the
// same cycle a waiting record leaves; while a record waits unread, input
// is held off.
// Reset (rst, synchronous): counters and line state cleared, registers back
// to delimiter 44, lenient mode, limit 0; no record pending.
// After end_of_input or an abort record the block swallows every further
// byte without output until reset.
module delimited_record_tokenizer_unit import drt_pkg::*; #(
  parameter int FIELD_MAX = FIELD_MAX_DEF,
  parameter int LINE_MAX  = LINE_MAX_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  drt_text_if.sink               text,
  drt_record_if.source           record,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  core_result_t result;
  logic         ready_up;
  logic         accept;

  // byte request taken this cycle
  assign text.ready = ready_up;
  assign accept     = text.valid && ready_up;

  drt_core #(
    .FIELD_MAX (FIELD_MAX),
    .LINE_MAX  (LINE_MAX)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .req       (text.payload),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .result    (result)
  );

  // single record register between core and receiver
  drt_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .result   (result),
    .ready_up (ready_up),
    .valid    (record.valid),
    .ready    (record.ready),
    .payload  (record.payload)
  );

endmodule

@@ hw/rtl/drt_checker.sv @@
`timescale 1ns / 1ps

module drt_checker import drt_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        rec_valid,
  input logic        rec_ready,
  input record_req_t rec
);

  // stalled record holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    rec_valid && !rec_ready |=> rec_valid && $stable(rec))
    else $error("record changed while stalled");

  // mid-line records carry a field and do not end the line
  a_within: assert property (@(posedge clk) disable iff (rst)
    rec_valid && rec.line_status == ST_WITHIN |-> rec.has_field && !rec.end_of_line)
    else $error("mid-line record malformed");

  // status-only records are empty and close the line
  a_status_only: assert property (@(posedge clk) disable iff (rst)
    rec_valid && !rec.has_field |->
      rec.end_of_line && rec.field_index == 6'd0 && rec.field_start == 16'd0 &&
      rec.field_length == 16'd0 && !rec.index_saturated &&
      (rec.line_status == ST_DROP_FEW || rec.line_status == ST_DROP_MANY ||
       rec.line_status == ST_ABORTED))
    else $error("status-only record malformed");

  // nothing follows an abort
  a_abort_last: assert property (@(posedge clk) disable iff (rst)
    rec_valid && rec_ready && rec.line_status == ST_ABORTED |=> !rec_valid)
    else $error("record after abort");

endmodule

bind delimited_record_tokenizer_unit drt_checker u_drt_checker (
  .clk       (clk),
  .rst       (rst),
  .rec_valid (record.valid),
  .rec_ready (record.ready),
  .rec       (record.payload)
);

@@ test/tb_top.sv @@
`timescale 1ns / 1ps

// Text requests go in one byte at a time; record requests come back, one per
// field end or line status. A shadow tokenizer runs on every accepted text
// request and queues the records it should cause. The checker pops one per
// accepted record request and compares field by field.
module tb_top;
  import drt_pkg::*;

  localparam int FIELD_LAST   = FIELD_MAX_DEF - 1;
  localparam int POS_LAST     = LINE_MAX_DEF - 1;
  localparam int RANDOM_BYTES = 800;
  localparam int QUIET_TAIL   = 300;   // last random bytes run with no idling
  localparam int SETTLE       = 4;     // extra margin for bytes that cause no record

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_wdata;
  logic                   rec_ready = 1'b0;
  bit                     idling = 1'b0;
  int                     stall_left = 0;

  drt_text_if   text_ch ();
  drt_record_if record_ch ();

  assign record_ch.ready = rec_ready;

  delimited_record_tokenizer_unit dut (
    .clk      (clk),
    .rst      (rst),
    .text     (text_ch),
    .record   (record_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shadow tokenizer: register copies and line state, all as after reset
  // ---------------------------------------------------------------------------
  logic [7:0]  delim_reg    = DELIMITER_RESET;
  logic [6:0]  expected_reg = '0;
  logic [31:0] limit_reg    = '0;

  logic [31:0] cur_line    = '0;
  logic [6:0]  fields_seen = '0;   // saturates at FIELD_MAX
  logic [15:0] line_pos    = '0;   // saturates at LINE_MAX-1
  logic [15:0] fld_start   = '0;
  logic        skip_row    = 1'b0; // rest of an over-long row is being skipped
  logic [31:0] bad_rows    = '0;
  logic        stopped     = 1'b0; // end of input or abort; only reset clears

  record_req_t pending_records[$];

  int mismatches   = 0;
  int records_seen = 0;
  int bytes_sent   = 0;            // NUL bytes are dropped, so not counted

  // expected_fields above FIELD_MAX behaves as FIELD_MAX; 0 means lenient
  function automatic int effective_need();
    return (int'(expected_reg) > FIELD_MAX_DEF) ? FIELD_MAX_DEF : int'(expected_reg);
  endfunction

  function automatic record_req_t status_record(input logic [2:0] st);
    record_req_t r;
    r = '0;
    r.line_number = cur_line;
    r.end_of_line = 1'b1;
    r.line_status = st;
    return r;
  endfunction

  function automatic record_req_t field_record(input logic eol, input logic [2:0] st);
    record_req_t r;
    r = '0;
    r.field_index     = (int'(fields_seen) < FIELD_LAST) ? fields_seen[5:0] : 6'(FIELD_LAST);
    r.field_start     = fld_start;
    r.field_length    = line_pos - fld_start;
    r.line_number     = cur_line;
    r.has_field       = 1'b1;
    r.end_of_line     = eol;
    r.line_status     = st;
    r.index_saturated = int'(fields_seen) >= FIELD_MAX_DEF;
    return r;
  endfunction

  function automatic void start_next_line();
    cur_line    = cur_line + 32'd1;   // wraps
    fields_seen = '0;
    line_pos    = '0;
    fld_start   = '0;
    skip_row    = 1'b0;
  endfunction

  function automatic void step_position();
    if (int'(line_pos) < POS_LAST) line_pos = line_pos + 16'd1;
  endfunction

  // returns 1 once the bad-row count passes the limit
  function automatic bit count_bad_row();
    if (bad_rows != '1) bad_rows = bad_rows + 32'd1;
    return bad_rows > limit_reg;
  endfunction

  // One accepted text request; queues the record it causes, if any.
  function automatic void tokenize_byte(input logic [7:0] b, input logic eoi);
    int need;
    int seen;
    bit strict_mode;
    need        = effective_need();
    strict_mode = need != 0;
    seen        = int'(fields_seen);
    if (stopped) return;
    if (eoi) begin
      stopped = 1'b1;   // partial line is thrown away
      return;
    end
    if (b == CHAR_NUL) return;
    // newline wins over the delimiter, whatever the delimiter is
    if (b == CHAR_NL) begin
      if (skip_row) begin
        pending_records.push_back(status_record(ST_DROP_MANY));
      end else if (strict_mode && (seen >= need || seen + 1 < need)) begin
        if (count_bad_row()) begin
          stopped = 1'b1;
          pending_records.push_back(status_record(ST_ABORTED));
          return;
        end
        pending_records.push_back(status_record(seen >= need ? ST_DROP_MANY : ST_DROP_FEW));
      end else begin
        pending_records.push_back(field_record(1'b1, ST_ACCEPTED));
      end
      start_next_line();
      return;
    end
    if (b == delim_reg) begin
      if (skip_row) begin
        step_position();
        return;
      end
      // surplus field found at a delimiter: row counted now, rest skipped
      if (strict_mode && seen >= need) begin
        step_position();
        if (count_bad_row()) begin
          stopped = 1'b1;
          pending_records.push_back(status_record(ST_ABORTED));
          return;
        end
        skip_row = 1'b1;
        return;
      end
      pending_records.push_back(field_record(1'b0, ST_WITHIN));
      if (seen < FIELD_MAX_DEF) fields_seen = fields_seen + 7'd1;
      step_position();
      fld_start = line_pos;
      return;
    end
    step_position();
  endfunction

  // ---------------------------------------------------------------------------
  // Record side: random stall bursts, and the comparison
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      rec_ready  <= 1'b0;
    end else if (idling && $urandom_range(0, 15) == 0) begin
      stall_left <= $urandom_range(0, 13);   // start a stall burst of random length
      rec_ready  <= 1'b0;
    end else begin
      rec_ready <= 1'b1;
    end
  end

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("record %0d: %s expected %0d, got %0d", records_seen, name, want, got);
    end
  endfunction

  always @(posedge clk) begin : check_records
    record_req_t want;
    record_req_t got;
    if (!rst && record_ch.valid && rec_ready) begin
      got = record_ch.payload;
      records_seen++;
      if (pending_records.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("record %0d: none expected, got line %0d status %0d", records_seen,
                   got.line_number, got.line_status);
      end else begin
        want = pending_records.pop_front();
        check_field("field_index", 32'(want.field_index), 32'(got.field_index));
        check_field("field_start", 32'(want.field_start), 32'(got.field_start));
        check_field("field_length", 32'(want.field_length), 32'(got.field_length));
        check_field("line_number", want.line_number, got.line_number);
        check_field("has_field", 32'(want.has_field), 32'(got.has_field));
        check_field("end_of_line", 32'(want.end_of_line), 32'(got.end_of_line));
        check_field("line_status", 32'(want.line_status), 32'(got.line_status));
        check_field("index_saturated", 32'(want.index_saturated), 32'(got.index_saturated));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Text side
  // ---------------------------------------------------------------------------

  // Starts and ends at a rising edge. valid stays high on return, so
  // back-to-back requests need no extra NBA on it.
  task automatic send_byte(input logic [7:0] b, input logic eoi);
    text_req_t req;
    req.data_byte    = b;
    req.end_of_input = eoi;
    if (idling && $urandom_range(0, 15) == 0) begin
      text_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    text_ch.valid   <= 1'b1;
    text_ch.payload <= req;
    do @(posedge clk); while (!text_ch.ready);
    tokenize_byte(b, eoi);
    if (b != CHAR_NUL) bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
  endtask

  // mostly plain text; now and then any byte at all, which may break the line
  function automatic logic [7:0] text_byte();
    logic [7:0] b;
    if ($urandom_range(0, 23) == 0) return 8'($urandom_range(0, 255));
    do b = 8'($urandom_range(0, 255));
    while (b == CHAR_NUL || b == CHAR_NL || b == delim_reg);
    return b;
  endfunction

  task automatic send_line(input int nfields, input int maxlen);
    int len;
    for (int f = 0; f < nfields; f++) begin
      if (f != 0) send_byte(delim_reg, 1'b0);
      len = $urandom_range(0, maxlen);
      for (int i = 0; i < len; i++) send_byte(text_byte(), 1'b0);
    end
    send_byte(CHAR_NL, 1'b0);
  endtask

  // fields of 0..2 lowercase letters, no noise; delimiter must be a comma
  task automatic send_clean_line(input int nfields);
    for (int f = 0; f < nfields; f++) begin
      if (f != 0) send_byte(delim_reg, 1'b0);
      repeat ($urandom_range(0, 2)) send_byte(8'($urandom_range(97, 122)), 1'b0);
    end
    send_byte(CHAR_NL, 1'b0);
  endtask

  // field count around the required one, so most rows are good and some
  // land on each side of it; in lenient mode mostly 1..8, sometimes 9..70
  function automatic int fields_for_line();
    int need;
    need = effective_need();
    if (delim_reg == CHAR_NUL || delim_reg == CHAR_NL) return 1;
    if (need == 0)
      return ($urandom_range(0, 15) == 0) ? $urandom_range(9, 70) : $urandom_range(1, 8);
    case ($urandom_range(0, 9))
      6:       return (need > 1) ? need - 1 : need + 1;
      7:       return need + 1;
      8:       return need + $urandom_range(2, 3);
      9:       return $urandom_range(1, need + 4);
      default: return need;
    endcase
  endfunction

  // let every expected record come out, then a few more cycles for bytes
  // that cause none
  task automatic drain();
    text_ch.valid <= 1'b0;
    while (pending_records.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // only while idle: all three registers, then write enable drops
  task automatic set_config(input logic [7:0] d, input logic [6:0] e, input logic [31:0] lim);
    cfg_we    <= 1'b1;
    cfg_index <= REG_DELIMITER;
    cfg_wdata <= 32'(d);
    @(posedge clk);
    cfg_index <= REG_EXPECTED_FIELDS;
    cfg_wdata <= 32'(e);
    @(posedge clk);
    cfg_index <= REG_BAD_ROW_LIMIT;
    cfg_wdata <= lim;
    @(posedge clk);
    cfg_we       <= 1'b0;
    delim_reg    = d;
    expected_reg = e;
    limit_reg    = lim;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // reset settings: comma splits, lenient; NUL inside a field, empty fields,
  // a 0xFF byte, an empty line
  task automatic test_defaults();
    send_text("ab,c,,");
    send_byte(CHAR_NUL, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(CHAR_NL, 1'b0);
    send_byte(CHAR_NL, 1'b0);
    drain();
  endtask

  // NUL or newline as delimiter means no splitting; 0xFF splits
  task automatic test_delimiter_extremes();
    set_config(CHAR_NUL, 7'd0, 32'd0);
    send_text("a,b");
    send_byte(CHAR_NUL, 1'b0);
    send_byte(CHAR_NL, 1'b0);
    drain();
    set_config(CHAR_NL, 7'd0, 32'd0);
    send_text("x,y\n");
    drain();
    set_config(8'hFF, 7'd0, 32'd0);
    send_text("p");
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_text("q\n");
    drain();
  endtask

  // three fields required: good row, too few, one too many (seen at the
  // newline), two too many (seen at a delimiter, rest skipped), empty row
  task automatic test_strict_rows();
    set_config(DELIMITER_RESET, 7'd3, 32'hFFFF_FFFF);
    send_text("a,b,c\n");
    send_text("a,b\n");
    send_text("a,b,c,d\n");
    send_text("a,b,c,d,e\n");
    send_text("\n");
    drain();
  endtask

  // index saturation in a lenient row of 70 fields; required count at 64 and
  // above it (127 acts as 64)
  task automatic test_field_limits();
    set_config(DELIMITER_RESET, 7'd0, 32'hFFFF_FFFF);
    send_clean_line(70);
    drain();
    set_config(DELIMITER_RESET, 7'd64, 32'hFFFF_FFFF);
    send_clean_line(64);
    drain();
    set_config(DELIMITER_RESET, 7'd127, 32'hFFFF_FFFF);
    send_clean_line(65);
    send_clean_line(66);
    send_clean_line(64);
    drain();
  endtask

  // one long line with wide starts and lengths; full rate, no idling
  task automatic test_long_line();
    drain();
    idling <= 1'b0;
    set_config(DELIMITER_RESET, 7'd0, 32'hFFFF_FFFF);
    repeat (300) send_byte(8'($urandom_range(97, 122)), 1'b0);
    send_byte(DELIMITER_RESET, 1'b0);
    repeat (60) send_byte(8'($urandom_range(97, 122)), 1'b0);
    send_byte(DELIMITER_RESET, 1'b0);
    repeat (2) send_byte(8'($urandom_range(97, 122)), 1'b0);
    send_byte(CHAR_NL, 1'b0);
    drain();
  endtask

  // phases of random settings and rows; the limit stays far above the bad
  // rows this part can produce, so no abort yet
  task automatic test_random_traffic();
    int          stop_at;
    int          phase_end;
    logic [7:0]  d;
    logic [6:0]  e;
    logic [31:0] lim;
    stop_at = bytes_sent + RANDOM_BYTES;
    while (bytes_sent < stop_at) begin
      drain();
      case ($urandom_range(0, 9))
        0:       d = CHAR_NUL;
        1:       d = CHAR_NL;
        2:       d = 8'hFF;
        3, 4, 5: d = DELIMITER_RESET;
        6:       d = 8'h09;
        default: d = 8'($urandom_range(1, 255));
      endcase
      case ($urandom_range(0, 7))
        0, 1, 2: e = 7'd0;
        3, 4, 5: e = 7'($urandom_range(1, 6));
        6:       e = 7'($urandom_range(7, 64));
        default: e = 7'($urandom_range(65, 127));
      endcase
      lim = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF : $urandom_range(32'hFFFF_FFFE, 100000);
      set_config(d, e, lim);
      idling <= (stop_at - bytes_sent > QUIET_TAIL) && ($urandom_range(0, 3) != 0);
      phase_end = bytes_sent + $urandom_range(60, 240);
      while (bytes_sent < phase_end && bytes_sent < stop_at)
        send_line(fields_for_line(), (effective_need() > 10) ? 2 : 6);
      // leave a line open now and then: the next settings apply mid-line
      if ($urandom_range(0, 1) == 1)
        repeat ($urandom_range(1, 6)) send_byte(text_byte(), 1'b0);
    end
  endtask

  // The run ends in one of the two stopping states, chosen at random: an
  // abort at the first bad row (limit 0), or end of input in mid-line.
  // Everything after is swallowed.
  task automatic test_halt();
    int need;
    drain();
    idling <= 1'b0;
    if ($urandom_range(0, 1) == 1) begin
      need = $urandom_range(2, 6);
      set_config(DELIMITER_RESET, 7'(need), 32'd0);
      repeat ($urandom_range(1, 3)) send_clean_line(need);
      case ($urandom_range(0, 2))
        0:       send_clean_line(need - 1);
        1:       send_clean_line(need + 1);
        default: send_clean_line(need + 3);
      endcase
    end else begin
      set_config(DELIMITER_RESET, 7'd0, 32'd0);
      send_clean_line(3);
      send_text("ab,c");
    end
    send_byte(8'($urandom_range(0, 255)), 1'b1);
    send_clean_line(2);
    send_byte(CHAR_NL, 1'b0);
    send_byte(8'($urandom_range(0, 255)), 1'b1);
    drain();
  endtask

  initial begin
    rst             = 1'b1;
    cfg_we          = 1'b0;
    cfg_index       = '0;
    cfg_wdata       = '0;
    text_ch.valid   = 1'b0;
    text_ch.payload = '0;
    repeat (5) @(posedge clk);
    rst    <= 1'b0;
    idling <= 1'b1;

    test_defaults();
    test_delimiter_extremes();
    test_strict_rows();
    test_field_limits();
    test_long_line();
    test_random_traffic();
    test_halt();

    if (mismatches == 0 && pending_records.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // timeout guard; a clean run needs a small fraction of it
  initial begin
    #20_000_000;
    $display("Timeout with %0d records outstanding", pending_records.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
